### hdl/b58_pkg.sv
// Package: shared types, constants and the character map of the base58 encoder.
package b58_pkg;

  localparam int DIGIT_W     = 6;
  localparam int CARRY_W     = 9;
  localparam int ACC_W       = 14;
  localparam int BASE        = 58;
  localparam int RECIP       = 18079;   // ceil(2^20 / 58)
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 15;
  localparam int PROD_W      = ACC_W + RECIP_W;
  localparam int MAX_OUT     = 45;
  localparam int OUT_CNT_W   = 6;
  localparam int CHAR_W      = 7;

  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

  localparam logic [7:0] ALPHA [0:BASE-1] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N", "P", "Q", "R", "S",
    "T", "U", "V", "W", "X", "Y", "Z",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "m", "n", "o", "p", "q", "r",
    "s", "t", "u", "v", "w", "x", "y", "z"
  };

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    S_ACCEPT = 5'b00001,
    S_DRAIN  = 5'b00010,
    S_SKIP   = 5'b00100,
    S_EMIT   = 5'b01000,
    S_CLEAR  = 5'b10000
  } state_t;

  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] idx;
    logic [7:0]         c;
    idx = (d > DIGIT_W'(BASE - 1)) ? DIGIT_W'(BASE - 1) : d;
    c = ALPHA[idx];
    return c[CHAR_W-1:0];
  endfunction

endpackage

### hdl/b58_if.sv
// Interfaces: valid/ready channels for message bytes and encoded characters.
interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;
  logic       overflow;

  modport source (output valid, output out_char, output out_last, output overflow, input ready);
  modport sink   (input valid, input out_char, input out_last, input overflow, output ready);
endinterface

### hdl/b58_cell.sv
// Digit cell: one base-58 digit, folds an incoming carry and passes the next carry up.
module b58_cell
  import b58_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic                cin_valid,
  input  logic [CARRY_W-1:0]  cin,
  input  logic [DIGIT_W-1:0]  shift_in,
  output logic [DIGIT_W-1:0]  digit,
  output logic                cout_valid,
  output logic [CARRY_W-1:0]  cout
);

  logic [ACC_W-1:0]   acc;
  logic [PROD_W-1:0]  prod;
  logic [CARRY_W-1:0] quo;
  logic [ACC_W-1:0]   rem_full;

  // digit*256 + carry, then divide by 58 through the reciprocal
  assign acc      = {digit, 8'b0} + ACC_W'(cin);
  assign prod     = PROD_W'(acc) * PROD_W'(RECIP);
  assign quo      = prod[RECIP_SHIFT +: CARRY_W];
  assign rem_full = acc - ACC_W'(quo) * ACC_W'(BASE);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= shift_in;
    end else if (cin_valid) begin
      digit <= rem_full[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout_valid <= 1'b0;
    end else begin
      cout_valid <= cin_valid;
    end
    cout <= quo;
  end

endmodule

### hdl/base58_encoder.sv
// Top level: base58 (Bitcoin alphabet) encoder built on a row of digit cells.
//
// Message bytes enter on msg, one beat per cycle while a message is open; every byte
// after the run of leading zero bytes starts a carry wave into a row of DIGITS cells,
// which moves up one cell per cycle, so several waves are in flight at once. Bytes past
// MAX_BYTES are dropped and flag overflow. After the beat with final_byte set, input is
// held off while the last wave drains, then leading zero digits are shifted out at one
// per cycle and the emission is set up, then characters leave on enc at one beat per
// cycle while enc is ready: one '1' per leading zero byte, then the digits, most
// significant first, at most 45 characters, out_last on the final one. A message that
// encodes to nothing produces no beat. A clearing state follows each message. The delay
// to the first character after the final beat is set by the carry ripple and the
// shift-out through the cell row, and the rest follow at one per cycle while enc is
// ready.
module base58_encoder
  import b58_pkg::*;
#(
  parameter int MAX_BYTES = 32,
  parameter int DIGITS    = 45
) (
  input  logic      clk,
  input  logic      rst,
  b58_in_if.sink    msg,
  b58_out_if.source enc
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int REM_W = $clog2(DIGITS + 1);
  localparam int TOT_W = ((CNT_W > REM_W) ? CNT_W : REM_W) + 1;

  state_t state;

  // message bookkeeping
  logic [CNT_W-1:0]     byte_count;
  logic [CNT_W-1:0]     zero_run;
  logic                 in_prefix;
  logic                 dropped;

  // carry injection into the first cell
  logic                 inj_valid;
  logic [CARRY_W-1:0]   inj;

  // emission counters
  logic [REM_W-1:0]     rem;
  logic [CNT_W-1:0]     ones_left;
  logic [OUT_CNT_W-1:0] n_out;
  logic                 ovf;

  // output register
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic                 out_last;
  logic                 out_ovf;

  // cell row
  logic [DIGIT_W-1:0]   digit      [DIGITS];
  logic [CARRY_W-1:0]   cout       [DIGITS];
  logic [DIGITS-1:0]    cout_valid;
  cell_ctrl_t           ctrl;

  logic                 accept;
  logic                 busy;
  logic                 top_zero;
  logic                 skip_shift;
  logic                 load;
  logic                 nothing;
  logic                 last_next;
  logic [TOT_W-1:0]     total;

  genvar gi;
  generate
    for (gi = 0; gi < DIGITS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        b58_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctrl       (ctrl),
          .cin_valid  (inj_valid),
          .cin        (inj),
          .shift_in   ({DIGIT_W{1'b0}}),
          .digit      (digit[gi]),
          .cout_valid (cout_valid[gi]),
          .cout       (cout[gi])
        );
      end else begin : g_next
        b58_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctrl       (ctrl),
          .cin_valid  (cout_valid[gi-1]),
          .cin        (cout[gi-1]),
          .shift_in   (digit[gi-1]),
          .digit      (digit[gi]),
          .cout_valid (cout_valid[gi]),
          .cout       (cout[gi])
        );
      end
    end
  endgenerate

  assign accept     = msg.valid && msg.ready;
  assign busy       = inj_valid || (|cout_valid);
  assign top_zero   = (digit[DIGITS-1] == '0);
  assign skip_shift = (state == S_SKIP) && (rem != '0) && top_zero;
  assign nothing    = (ones_left == '0) && (rem == '0);
  assign load       = (state == S_EMIT) && !nothing && (!out_valid || enc.ready);
  assign total      = TOT_W'(zero_run) + TOT_W'(rem);

  // last character: output limit reached, or nothing left after this one
  always_comb begin
    if (ones_left != '0) begin
      last_next = (ones_left == CNT_W'(1)) && (rem == '0);
    end else begin
      last_next = (rem == REM_W'(1));
    end
    if (n_out == OUT_CNT_W'(MAX_OUT - 1)) begin
      last_next = 1'b1;
    end
  end

  always_comb begin
    ctrl.shift = skip_shift || (load && (ones_left == '0));
    ctrl.clear = (state == S_CLEAR);
  end

  assign msg.ready    = (state == S_ACCEPT);
  assign enc.valid    = out_valid;
  assign enc.out_char = out_char;
  assign enc.out_last = out_last;
  assign enc.overflow = out_ovf;

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_ACCEPT;
      byte_count <= '0;
      zero_run   <= '0;
      in_prefix  <= 1'b1;
      dropped    <= 1'b0;
      inj_valid  <= 1'b0;
      rem        <= '0;
      ones_left  <= '0;
      n_out      <= '0;
      ovf        <= 1'b0;
    end else begin
      inj_valid <= 1'b0;

      // carry leaving the top cell means the store wrapped
      if (cout_valid[DIGITS-1] && (cout[DIGITS-1] != '0)) begin
        dropped <= 1'b1;
      end

      case (state)
        S_ACCEPT: begin
          if (accept) begin
            if (byte_count < CNT_W'(MAX_BYTES)) begin
              byte_count <= byte_count + 1'b1;
              if (in_prefix && (msg.data_byte == '0)) begin
                zero_run <= zero_run + 1'b1;
              end else begin
                in_prefix <= 1'b0;
                inj_valid <= 1'b1;
              end
            end else begin
              dropped <= 1'b1;
            end
            if (msg.final_byte) begin
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // hold until every carry wave has left the row
          if (!busy) begin
            rem   <= REM_W'(DIGITS);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_shift) begin
            rem <= rem - 1'b1;
          end else begin
            ovf       <= dropped || (total > TOT_W'(MAX_OUT));
            ones_left <= zero_run;
            n_out     <= '0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (nothing) begin
            state <= S_CLEAR;
          end else if (load) begin
            n_out <= n_out + 1'b1;
            if (ones_left != '0) begin
              ones_left <= ones_left - 1'b1;
            end else begin
              rem <= rem - 1'b1;
            end
            if (last_next) begin
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          byte_count <= '0;
          zero_run   <= '0;
          in_prefix  <= 1'b1;
          dropped    <= 1'b0;
          state      <= S_ACCEPT;
        end
        default: begin
          state <= S_ACCEPT;
        end
      endcase
    end
  end

  // injected carry payload: the message byte itself
  always_ff @(posedge clk) begin
    if (accept) begin
      inj <= CARRY_W'(msg.data_byte);
    end
  end

  // output register: hold a beat until taken, load the next one in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (enc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= (ones_left != '0) ? CHAR_ONE : b58_char(digit[DIGITS-1]);
      out_last <= last_next;
      out_ovf  <= ovf;
    end
  end

endmodule
